@@ rtl/core/hss_pkg.sv @@
// Shared constants, item and stage types for the Hermite smoothstep pipeline.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package hss_pkg;

  // Value width and fraction bits of the signed fixed-point format (Q16.16).
  localparam int DW = 32;
  localparam int FB = 16;

  // Width of the signed polynomial and basis values p, b0 and b1.
  localparam int BW = FB + 3;
  // Width of a basis magnitude.
  localparam int MW = FB + 2;
  // Width of a basis-times-slope product and of its quotient by the range.
  localparam int PW = MW + DW;
  // Width of the signed sum before saturation.
  localparam int SW = PW + 2;

  // Register index width and register indexes of the configuration port.
  localparam int RIW = 2;

  typedef enum logic [RIW-1:0] {
    REG_RANGE_LOW   = 2'd0,
    REG_RANGE_HIGH  = 2'd1,
    REG_SLOPE_START = 2'd2,
    REG_SLOPE_END   = 2'd3
  } hss_reg_e;

  // Which side of the transition band a sample falls on.
  typedef struct packed {
    logic above;
    logic below;
  } hss_flag_t;

  // Into the ratio divider: offset of the sample from the lower edge.
  typedef struct packed {
    hss_flag_t       flags;
    logic [DW-1:0]   num;
  } hss_ratio_in_t;

  // Out of the ratio divider: normalized position h in Q0.FB.
  typedef struct packed {
    hss_flag_t       flags;
    logic [FB-1:0]   h;
  } hss_ratio_out_t;

  // Through the term dividers. On entry m0 and m1 hold the products to divide;
  // on exit they hold the quotients.
  typedef struct packed {
    hss_flag_t              flags;
    logic signed [BW-1:0]   p;
    logic                   neg0;
    logic                   neg1;
    logic [PW-1:0]          m0;
    logic [PW-1:0]          m1;
  } hss_term_t;

endpackage

`default_nettype wire

@@ rtl/core/hss_ratio_div.sv @@
// Pipelined restoring divider that forms h = floor(num * 2^FB / dv), one bit per stage.
// Depends on hss_pkg.
`default_nettype none

module hss_ratio_div (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   en,
  input  wire logic                   in_valid,
  input  wire hss_pkg::hss_ratio_in_t in_data,
  input  wire logic [hss_pkg::DW-1:0] dv,
  output logic                        out_valid,
  output hss_pkg::hss_ratio_out_t     out_data
);
  import hss_pkg::*;

  logic            vld_r [FB];
  logic [DW:0]     rem_r [FB];
  logic [FB-1:0]   q_r   [FB];
  hss_flag_t       flg_r [FB];

  // The offset is below dv for any sample inside the band, so it is already
  // a valid partial remainder and only the FB fraction bits remain to be found.
  for (genvar s = 0; s < FB; s++) begin : g_st
    logic          v_i;
    logic [DW:0]   rem_i;
    logic [FB-1:0] q_i;
    hss_flag_t     f_i;
    logic [DW:0]   sh;
    logic          ge;
    logic [DW:0]   rem_nxt;
    logic [FB-1:0] q_nxt;

    if (s == 0) begin : g_first
      assign v_i   = in_valid;
      assign rem_i = {1'b0, in_data.num};
      assign q_i   = '0;
      assign f_i   = in_data.flags;
    end else begin : g_next
      assign v_i   = vld_r[s-1];
      assign rem_i = rem_r[s-1];
      assign q_i   = q_r[s-1];
      assign f_i   = flg_r[s-1];
    end

    always_comb begin
      sh      = {rem_i[DW-1:0], 1'b0};
      ge      = (sh >= {1'b0, dv});
      rem_nxt = ge ? (sh - {1'b0, dv}) : sh;
      q_nxt   = {q_i[FB-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_nxt;
        q_r[s]   <= q_nxt;
        flg_r[s] <= f_i;
      end
    end
  end

  assign out_valid      = vld_r[FB-1];
  assign out_data.flags = flg_r[FB-1];
  assign out_data.h     = q_r[FB-1];

endmodule

`default_nettype wire

@@ rtl/core/hss_poly.sv @@
// Four-stage polynomial unit: h^2, h^3, smoothstep and basis values, slope products.
// Depends on hss_pkg.
`default_nettype none

module hss_poly (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    en,
  input  wire logic                    in_valid,
  input  wire hss_pkg::hss_ratio_out_t in_data,
  input  wire logic [hss_pkg::DW-1:0]  slope_start,
  input  wire logic [hss_pkg::DW-1:0]  slope_end,
  output logic                         out_valid,
  output hss_pkg::hss_term_t           out_data
);
  import hss_pkg::*;

  logic [3:0] vld_r;

  // Stage 1: square.
  hss_flag_t     f1_r;
  logic [FB-1:0] h1_r, h2a_r;
  logic [2*FB-1:0] sq;
  // Stage 2: cube.
  hss_flag_t     f2_r;
  logic [FB-1:0] h1b_r, h2b_r, h3_r;
  logic [2*FB-1:0] cu;
  // Stage 3: polynomial and basis magnitudes.
  hss_flag_t            f3_r;
  logic signed [BW-1:0] p3_r;
  logic [MW-1:0]        mb0_r, mb1_r;
  logic [DW-1:0]        ms0_r, ms1_r;
  logic                 ng0_r, ng1_r;
  logic signed [BW-1:0] hs, h2s, h3s, p_nxt, b0, b1;
  logic [BW-1:0]        ab0, ab1;
  // Stage 4: products.
  hss_term_t            t4_r;

  assign sq = (2*FB)'(in_data.h) * (2*FB)'(in_data.h);
  assign cu = (2*FB)'(h2a_r) * (2*FB)'(h1_r);

  always_comb begin
    hs    = $signed({3'b000, h1b_r});
    h2s   = $signed({3'b000, h2b_r});
    h3s   = $signed({3'b000, h3_r});
    p_nxt = (h2s <<< 1) + h2s - (h3s <<< 1);
    b0    = h3s - (h2s <<< 1) + hs;
    b1    = h3s - h2s;
    ab0   = b0[BW-1] ? (-b0) : b0;
    ab1   = b1[BW-1] ? (-b1) : b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_r  <= in_data.flags;
      h1_r  <= in_data.h;
      h2a_r <= sq[2*FB-1:FB];

      f2_r  <= f1_r;
      h1b_r <= h1_r;
      h2b_r <= h2a_r;
      h3_r  <= cu[2*FB-1:FB];

      f3_r  <= f2_r;
      p3_r  <= p_nxt;
      mb0_r <= ab0[MW-1:0];
      mb1_r <= ab1[MW-1:0];
      ms0_r <= slope_start[DW-1] ? (-slope_start) : slope_start;
      ms1_r <= slope_end[DW-1] ? (-slope_end) : slope_end;
      ng0_r <= b0[BW-1] ^ slope_start[DW-1];
      ng1_r <= b1[BW-1] ^ slope_end[DW-1];

      t4_r.flags <= f3_r;
      t4_r.p     <= p3_r;
      t4_r.neg0  <= ng0_r;
      t4_r.neg1  <= ng1_r;
      t4_r.m0    <= PW'(mb0_r) * PW'(ms0_r);
      t4_r.m1    <= PW'(mb1_r) * PW'(ms1_r);
    end
  end

  assign out_valid = vld_r[3];
  assign out_data  = t4_r;

endmodule

`default_nettype wire

@@ rtl/core/hss_term_div.sv @@
// Two-lane pipelined restoring divider for the slope terms, one quotient bit per stage.
// Depends on hss_pkg.
`default_nettype none

module hss_term_div (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   en,
  input  wire logic                   in_valid,
  input  wire hss_pkg::hss_term_t     in_data,
  input  wire logic [hss_pkg::DW-1:0] dv,
  output logic                        out_valid,
  output hss_pkg::hss_term_t          out_data
);
  import hss_pkg::*;

  logic       vld_r [PW];
  hss_term_t  d_r   [PW];
  logic [DW:0] r0_r [PW];
  logic [DW:0] r1_r [PW];

  // Each m field works as a shift register: the dividend leaves at the top
  // while quotient bits enter at the bottom.
  for (genvar s = 0; s < PW; s++) begin : g_st
    logic        v_i;
    hss_term_t   d_i, d_nxt;
    logic [DW:0] r0_i, r1_i, sh0, sh1, r0_nxt, r1_nxt;
    logic        ge0, ge1;

    if (s == 0) begin : g_first
      assign v_i  = in_valid;
      assign d_i  = in_data;
      assign r0_i = '0;
      assign r1_i = '0;
    end else begin : g_next
      assign v_i  = vld_r[s-1];
      assign d_i  = d_r[s-1];
      assign r0_i = r0_r[s-1];
      assign r1_i = r1_r[s-1];
    end

    always_comb begin
      sh0      = {r0_i[DW-1:0], d_i.m0[PW-1]};
      sh1      = {r1_i[DW-1:0], d_i.m1[PW-1]};
      ge0      = (sh0 >= {1'b0, dv});
      ge1      = (sh1 >= {1'b0, dv});
      r0_nxt   = ge0 ? (sh0 - {1'b0, dv}) : sh0;
      r1_nxt   = ge1 ? (sh1 - {1'b0, dv}) : sh1;
      d_nxt    = d_i;
      d_nxt.m0 = {d_i.m0[PW-2:0], ge0};
      d_nxt.m1 = {d_i.m1[PW-2:0], ge1};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_r[s]  <= d_nxt;
        r0_r[s] <= r0_nxt;
        r1_r[s] <= r1_nxt;
      end
    end
  end

  assign out_valid = vld_r[PW-1];
  assign out_data  = d_r[PW-1];

endmodule

`default_nettype wire

@@ rtl/core/hermite_smoothstep_with_slopes.sv @@
// Top level of the cubic Hermite smoothstep with end slopes.
// Depends on hss_pkg, hss_ratio_div, hss_poly and hss_term_div.
`default_nettype none

// The block maps each signed Q16.16 sample to a cubic Hermite smoothstep in
// Q16.16. A sample at or above range_high gives 1.0, a sample below range_low
// gives 0.0, and anything between is normalized to h = (x - low) / (high - low)
// and shaped as 3h^2 - 2h^3 plus the two slope terms, each slope divided by
// the range and truncated toward zero; the sum saturates to the signed 32-bit
// range. The block is a fully pipelined datapath with no state between items:
// one item enters per clock unless the result side stalls, and passes one input
// register, 16 stages of the ratio divider, four stages of multiplies, 50
// stages of the slope-term dividers and two stages of sum and saturation.
// The whole pipeline advances together whenever the output register is empty
// or being taken, so a stall on the result side holds every item in place.
// Registers are written through the cfg port and must only change while no
// item is in flight.

module hermite_smoothstep_with_slopes (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // Input stream. tdata: sample_value[31:0].
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [hss_pkg::DW-1:0]    in_tdata,
  // Result stream. tdata: shaped_value[31:0].
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [hss_pkg::DW-1:0]         out_tdata,
  // Configuration writes.
  input  wire logic                      cfg_wr_en,
  input  wire logic [hss_pkg::RIW-1:0]   cfg_addr,
  input  wire logic [hss_pkg::DW-1:0]    cfg_wdata
);
  import hss_pkg::*;

  // Configuration registers.
  logic [DW-1:0] low_r, high_r, sl0_r, sl1_r;
  logic [DW-1:0] dv;

  // Global advance: everything moves when the output register can take a result.
  logic en;

  // Input register.
  logic          in_vld_r;
  logic [DW-1:0] smp_r;

  hss_ratio_in_t  rin;
  logic           rdv_v;
  hss_ratio_out_t rdv_d;
  logic           ply_v;
  hss_term_t      ply_d;
  logic           tdv_v;
  hss_term_t      tdv_d;

  // Sum stage.
  logic                 sum_vld_r;
  logic signed [SW-1:0] sum_r, sum_nxt, t0, t1;
  logic [DW-1:0]        sat;

  logic          out_vld_r;
  logic [DW-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= '0;
      high_r <= DW'(1) << FB;
      sl0_r  <= '0;
      sl1_r  <= '0;
    end else if (cfg_wr_en) begin
      case (hss_reg_e'(cfg_addr))
        REG_RANGE_LOW:   low_r  <= cfg_wdata;
        REG_RANGE_HIGH:  high_r <= cfg_wdata;
        REG_SLOPE_START: sl0_r  <= cfg_wdata;
        REG_SLOPE_END:   sl1_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Only meaningful inside the band, where it lies between 1 and 2^32 - 1.
  assign dv = high_r - low_r;

  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (en) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      smp_r <= in_tdata;
    end
  end

  // Classify the sample and form its offset from the lower edge.
  always_comb begin
    rin.flags.above = ($signed(smp_r) >= $signed(high_r));
    rin.flags.below = !rin.flags.above && ($signed(smp_r) < $signed(low_r));
    rin.num         = smp_r - low_r;
  end

  hss_ratio_div u_ratio (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_vld_r),
    .in_data   (rin),
    .dv        (dv),
    .out_valid (rdv_v),
    .out_data  (rdv_d)
  );

  hss_poly u_poly (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (rdv_v),
    .in_data     (rdv_d),
    .slope_start (sl0_r),
    .slope_end   (sl1_r),
    .out_valid   (ply_v),
    .out_data    (ply_d)
  );

  hss_term_div u_term (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (ply_v),
    .in_data   (ply_d),
    .dv        (dv),
    .out_valid (tdv_v),
    .out_data  (tdv_d)
  );

  // Apply the signs to the slope quotients and add them to the smoothstep.
  // Outside the band the sum is replaced by 1.0 or 0.0.
  always_comb begin
    t0 = tdv_d.neg0 ? -$signed({2'b00, tdv_d.m0}) : $signed({2'b00, tdv_d.m0});
    t1 = tdv_d.neg1 ? -$signed({2'b00, tdv_d.m1}) : $signed({2'b00, tdv_d.m1});
    if (tdv_d.flags.above) begin
      sum_nxt = SW'(1) << FB;
    end else if (tdv_d.flags.below) begin
      sum_nxt = '0;
    end else begin
      sum_nxt = SW'(tdv_d.p) + t0 + t1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      sum_vld_r <= tdv_v;
      out_vld_r <= sum_vld_r;
    end
  end

  // Saturate: the sum fits when all bits above the result's sign bit agree with it.
  always_comb begin
    if ((sum_r[SW-1:DW-1] == '0) || (sum_r[SW-1:DW-1] == '1)) begin
      sat = sum_r[DW-1:0];
    end else if (sum_r[SW-1]) begin
      sat = {1'b1, {(DW-1){1'b0}}};
    end else begin
      sat = {1'b0, {(DW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r      <= sum_nxt;
      out_data_r <= sat;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire
